@@ hdl/glzw_pkg.sv @@
package glzw_pkg;

    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_PUSH  = 2'd1;
    localparam logic [1:0] MODE_PULL  = 2'd2;

    localparam logic [2:0] ST_PIXEL    = 3'd0;
    localparam logic [2:0] ST_NEED     = 3'd1;
    localparam logic [2:0] ST_ACCEPTED = 3'd2;
    localparam logic [2:0] ST_DONE     = 3'd3;
    localparam logic [2:0] ST_ERROR    = 3'd4;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_CODE_SIZE = 3'd1;
    localparam logic [2:0] ERR_BEYOND    = 3'd2;
    localparam logic [2:0] ERR_NO_PRIOR  = 3'd3;
    localparam logic [2:0] ERR_ENDED     = 3'd4;
    localparam logic [2:0] ERR_OVERRUN   = 3'd5;

    localparam logic [1:0] FIN_ACTIVE = 2'd0;
    localparam logic [1:0] FIN_DONE   = 2'd1;
    localparam logic [1:0] FIN_ERROR  = 2'd2;

    localparam logic [1:0] CFG_MIN_CODE = 2'd0;
    localparam logic [1:0] CFG_WIDTH    = 2'd1;
    localparam logic [1:0] CFG_HEIGHT   = 2'd2;
    localparam logic [1:0] CFG_INTERLACE = 2'd3;

    // interlace pass step and start row; passes past the fourth hold at zero
    function automatic logic [3:0] pass_step(input logic [2:0] p);
        case (p)
            3'd0: pass_step = 4'd8;
            3'd1: pass_step = 4'd8;
            3'd2: pass_step = 4'd4;
            3'd3: pass_step = 4'd2;
            default: pass_step = 4'd0;
        endcase
    endfunction

    function automatic logic [2:0] pass_start(input logic [2:0] p);
        case (p)
            3'd1: pass_start = 3'd4;
            3'd2: pass_start = 3'd2;
            3'd3: pass_start = 3'd1;
            default: pass_start = 3'd0;
        endcase
    endfunction

    typedef struct packed {
        logic [2:0]  status;
        logic [2:0]  cause;
        logic [7:0]  index;
        logic [15:0] row;
        logic [15:0] column;
        logic        row_complete;
        logic        in_frame;
    } glzw_result_t;

endpackage

@@ hdl/glzw_raster.sv @@
module glzw_raster
    import glzw_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        restart,
    input  logic        advance,
    input  logic [15:0] image_width,
    input  logic [15:0] image_height,
    input  logic        interlaced,
    output logic [15:0] row,
    output logic [15:0] column,
    output logic        row_complete,
    output logic        in_frame,
    output logic        last_row
);

    logic [15:0] row_reg, col_reg, rows_left_reg;
    logic [2:0]  pass_reg;
    logic [16:0] col_inc, row_sum;
    logic [2:0]  pass_nx;

    assign col_inc      = {1'b0, col_reg} + 17'd1;
    assign row_complete = col_inc >= {1'b0, image_width};
    assign in_frame     = row_reg < image_height;
    assign row          = row_reg;
    assign column       = col_reg;
    assign last_row     = rows_left_reg <= 16'd1;
    assign row_sum      = {1'b0, row_reg} + {13'd0, pass_step(pass_reg)};
    assign pass_nx      = (pass_reg < 3'd5) ? pass_reg + 3'd1 : pass_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            row_reg       <= '0;
            col_reg       <= '0;
            pass_reg      <= '0;
            rows_left_reg <= image_height;
        end else if (advance) begin
            if (!row_complete) begin
                col_reg <= col_inc[15:0];
            end else begin
                col_reg <= '0;
                if (interlaced) begin
                    if (row_sum >= {1'b0, image_height}) begin
                        pass_reg <= pass_nx;
                        row_reg  <= {13'd0, pass_start(pass_nx)};
                    end else begin
                        row_reg <= row_sum[15:0];
                    end
                end else begin
                    row_reg <= row_reg + 16'd1;
                end
                rows_left_reg <= last_row ? 16'd0 : rows_left_reg - 16'd1;
            end
        end
    end

endmodule

@@ hdl/gif_lzw_pixel_decoder.sv @@
// Sequence: start, push and mode 3 go from dispatch to the response state; a pull that
//   ends in need_data, image_done or error responds from fetch; a pull that pops a stacked
//   symbol passes pop, pop_wait and emit; a pull that decodes a code walks its prefix chain
//   (test, chase, chase_wait per link) and then finish and emit, after any clear codes read.
// Throughput: one word at a time; s_ready is low while a word is in work or while a
//   result waits on m_ready. Reset: aresetn (synchronous, active low) loads register
//   defaults and a start.
module gif_lzw_pixel_decoder
    import glzw_pkg::*;
#(
    parameter int MAX_CODE_BITS = 12
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [2:0]  m_error_cause,
    output logic [7:0]  m_pixel_index,
    output logic [15:0] m_pixel_row,
    output logic [15:0] m_pixel_column,
    output logic        m_row_complete,
    output logic        m_in_frame
);

    localparam int TD = 1 << MAX_CODE_BITS;
    localparam int CW = MAX_CODE_BITS + 1;   // code values up to the table size

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_FETCH, S_TEST, S_CHASE, S_CHASE_WAIT,
        S_FINISH, S_POP, S_POP_WAIT, S_EMIT, S_RESP
    } state_t;

    // configuration
    logic [3:0]  min_code_reg;
    logic [15:0] width_reg, height_reg;
    logic        interlace_reg;

    // table memories and expand stack
    logic [MAX_CODE_BITS-1:0] prefix_mem [TD];
    logic [7:0]               suffix_mem [TD];
    logic [7:0]               stack_mem  [TD];
    logic [MAX_CODE_BITS-1:0] prefix_rd;
    logic [7:0]               suffix_rd, stack_rd;

    state_t      state_reg;
    logic        boot_reg;
    logic [1:0]  mode_reg;
    logic [7:0]  byte_reg;
    logic [CW:0] depth_reg;
    logic [23:0] bitbuf_reg;
    logic [4:0]  bitcnt_reg;
    logic [7:0]  blk_left_reg;
    logic        ended_reg;
    logic [3:0]  lzw_min_reg;
    logic [3:0]  cwidth_reg;
    logic [CW-1:0] free_reg, prev_reg, code_reg, ch_reg;
    logic        prev_ok_reg;
    logic [7:0]  first_reg, sym_reg;
    logic [1:0]  fin_reg;
    logic [2:0]  cause_reg;
    glzw_result_t res_reg;
    logic        m_valid_reg;

    logic        ras_restart, ras_adv;
    logic [15:0] ras_row, ras_col;
    logic        ras_rc, ras_inf, ras_last;

    logic [CW-1:0] clear_code;
    logic [CW-1:0] code_now;
    logic          push_overrun;
    logic          kwk_write;

    assign clear_code = CW'(1) << lzw_min_reg;
    assign code_now   = CW'(bitbuf_reg & ((24'd1 << cwidth_reg) - 24'd1));

    // a data byte that finds the bit buffer too full to take it
    assign push_overrun = (mode_reg == MODE_PUSH) && (fin_reg == FIN_ACTIVE) && !ended_reg
                          && (blk_left_reg != 8'd0) && (bitcnt_reg > 5'd16);

    // repeat code with a previous string: the stack bottom gets the old head symbol
    assign kwk_write = (state_reg == S_FETCH) && (fin_reg == FIN_ACTIVE)
                       && (depth_reg == '0)
                       && ({1'b0, bitcnt_reg} >= {2'b0, cwidth_reg})
                       && (code_now == free_reg) && prev_ok_reg;

    glzw_raster u_raster (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .restart      (ras_restart),
        .advance      (ras_adv),
        .image_width  (width_reg),
        .image_height (height_reg),
        .interlaced   (interlace_reg),
        .row          (ras_row),
        .column       (ras_col),
        .row_complete (ras_rc),
        .in_frame     (ras_inf),
        .last_row     (ras_last)
    );

    assign ras_restart = (state_reg == S_DISPATCH) && (mode_reg == MODE_START);
    assign ras_adv     = (state_reg == S_EMIT);

    // configuration port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_code_reg  <= 4'd8;
            width_reg     <= 16'd1;
            height_reg    <= 16'd1;
            interlace_reg <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_MIN_CODE:  min_code_reg  <= cfg_data[3:0];
                CFG_WIDTH:     width_reg     <= cfg_data;
                CFG_HEIGHT:    height_reg    <= cfg_data;
                CFG_INTERLACE: interlace_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // memories: one write per cycle on each, registered reads
    logic                     tab_we, stk_we;
    logic [MAX_CODE_BITS-1:0] tab_wa, tab_ra, stk_wa, stk_ra;
    logic [MAX_CODE_BITS-1:0] tab_wp;
    logic [7:0]               tab_ws, stk_wd;

    always_ff @(posedge aclk) begin
        if (tab_we) begin
            prefix_mem[tab_wa] <= tab_wp;
            suffix_mem[tab_wa] <= tab_ws;
        end
        prefix_rd <= prefix_mem[tab_ra];
        suffix_rd <= suffix_mem[tab_ra];
    end

    always_ff @(posedge aclk) begin
        if (stk_we) begin
            stack_mem[stk_wa] <= stk_wd;
        end
        stack_rd <= stack_mem[stk_ra];
    end

    assign tab_ra = ch_reg[MAX_CODE_BITS-1:0];
    assign stk_ra = MAX_CODE_BITS'(depth_reg - (CW+1)'(1));

    always_comb begin
        tab_we = 1'b0;
        tab_wa = free_reg[MAX_CODE_BITS-1:0];
        tab_wp = prev_reg[MAX_CODE_BITS-1:0];
        tab_ws = first_reg;
        stk_we = 1'b0;
        stk_wa = depth_reg[MAX_CODE_BITS-1:0];
        stk_wd = suffix_rd;
        if (kwk_write) begin
            stk_we = 1'b1;
            stk_wa = '0;
            stk_wd = first_reg;
        end else if (state_reg == S_CHASE_WAIT) begin
            stk_we = 1'b1;
        end
        if (state_reg == S_FINISH && free_reg < CW'(TD) && prev_ok_reg) begin
            tab_we = 1'b1;
            tab_ws = ch_reg[7:0];
        end
    end

    assign s_ready = (state_reg == S_IDLE) && !m_valid_reg;
    assign m_valid = m_valid_reg;

    // sequencer; the table address unit is reused for every chain link
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_DISPATCH;
            boot_reg    <= 1'b1;
            mode_reg    <= MODE_START;
            m_valid_reg <= 1'b0;
            depth_reg   <= '0;
            fin_reg     <= FIN_ACTIVE;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
                    if (s_valid && s_ready) begin
                        mode_reg  <= s_mode;
                        byte_reg  <= s_data_byte;
                        state_reg <= S_DISPATCH;
                    end
                end
                S_DISPATCH: begin
                    boot_reg <= 1'b0;
                    if (push_overrun) begin
                        res_reg <= '{status: ST_ERROR, cause: ERR_OVERRUN, default: '0};
                    end else begin
                        res_reg <= '{status: ST_ACCEPTED, cause: ERR_NONE, default: '0};
                    end
                    // drop the response of the start made by reset
                    if (mode_reg == MODE_PULL) state_reg <= S_FETCH;
                    else if (boot_reg) state_reg <= S_IDLE;
                    else state_reg <= S_RESP;
                    case (mode_reg)
                        MODE_START: begin
                            lzw_min_reg  <= min_code_reg;
                            depth_reg    <= '0;
                            bitbuf_reg   <= '0;
                            bitcnt_reg   <= '0;
                            blk_left_reg <= '0;
                            ended_reg    <= 1'b0;
                            cwidth_reg   <= min_code_reg + 4'd1;
                            free_reg     <= (CW'(1) << min_code_reg) + CW'(2);
                            prev_ok_reg  <= 1'b0;
                            prev_reg     <= '0;
                            first_reg    <= '0;
                            if (min_code_reg < 4'd2 || min_code_reg > 4'd8) begin
                                fin_reg   <= FIN_ERROR;
                                cause_reg <= ERR_CODE_SIZE;
                            end else begin
                                fin_reg   <= FIN_ACTIVE;
                                cause_reg <= ERR_NONE;
                            end
                        end
                        MODE_PUSH: begin
                            if (fin_reg != FIN_ACTIVE || ended_reg) begin
                                // ignore
                            end else if (blk_left_reg == 8'd0) begin
                                if (byte_reg == 8'd0) ended_reg <= 1'b1;
                                else blk_left_reg <= byte_reg;
                            end else if (bitcnt_reg > 5'd16) begin
                                // drop the byte; the result reports the overrun
                            end else begin
                                bitbuf_reg   <= bitbuf_reg | (24'(byte_reg) << bitcnt_reg);
                                bitcnt_reg   <= bitcnt_reg + 5'd8;
                                blk_left_reg <= blk_left_reg - 8'd1;
                            end
                        end
                        default: ;
                    endcase
                end
                S_FETCH: begin
                    if (fin_reg == FIN_DONE) begin
                        res_reg.status <= ST_DONE;
                        state_reg      <= S_RESP;
                    end else if (fin_reg != FIN_ACTIVE) begin
                        res_reg.status <= ST_ERROR;
                        res_reg.cause  <= cause_reg;
                        state_reg      <= S_RESP;
                    end else if (depth_reg != '0) begin
                        state_reg <= S_POP;
                    end else if ({1'b0, bitcnt_reg} < {2'b0, cwidth_reg}) begin
                        state_reg <= S_RESP;
                        if (ended_reg) begin
                            fin_reg        <= FIN_ERROR;
                            cause_reg      <= ERR_ENDED;
                            res_reg.status <= ST_ERROR;
                            res_reg.cause  <= ERR_ENDED;
                        end else begin
                            res_reg.status <= ST_NEED;
                        end
                    end else begin
                        bitbuf_reg <= bitbuf_reg >> cwidth_reg;
                        bitcnt_reg <= bitcnt_reg - {1'b0, cwidth_reg};
                        code_reg   <= code_now;
                        if (code_now == clear_code + CW'(1)) begin
                            fin_reg        <= FIN_DONE;
                            res_reg.status <= ST_DONE;
                            state_reg      <= S_RESP;
                        end else if (code_now > free_reg) begin
                            fin_reg        <= FIN_ERROR;
                            cause_reg      <= ERR_BEYOND;
                            depth_reg      <= '0;
                            res_reg.status <= ST_ERROR;
                            res_reg.cause  <= ERR_BEYOND;
                            state_reg      <= S_RESP;
                        end else if (code_now == clear_code) begin
                            cwidth_reg  <= lzw_min_reg + 4'd1;
                            free_reg    <= clear_code + CW'(2);
                            prev_ok_reg <= 1'b0;
                            prev_reg    <= '0;
                            first_reg   <= '0;
                            state_reg   <= S_FETCH;
                        end else if (code_now == free_reg) begin
                            if (!prev_ok_reg) begin
                                fin_reg        <= FIN_ERROR;
                                cause_reg      <= ERR_NO_PRIOR;
                                depth_reg      <= '0;
                                res_reg.status <= ST_ERROR;
                                res_reg.cause  <= ERR_NO_PRIOR;
                                state_reg      <= S_RESP;
                            end else begin
                                depth_reg <= (CW+1)'(1);
                                ch_reg    <= prev_reg;
                                state_reg <= S_TEST;
                            end
                        end else begin
                            ch_reg    <= code_now;
                            state_reg <= S_TEST;
                        end
                    end
                end
                S_TEST: begin
                    if (ch_reg >= clear_code && depth_reg < (CW+1)'(TD)) state_reg <= S_CHASE;
                    else state_reg <= S_FINISH;
                end
                S_CHASE: state_reg <= S_CHASE_WAIT;   // table read in flight
                S_CHASE_WAIT: begin
                    depth_reg <= depth_reg + (CW+1)'(1);
                    ch_reg    <= CW'(prefix_rd);
                    state_reg <= S_TEST;
                end
                S_FINISH: begin
                    first_reg   <= ch_reg[7:0];
                    sym_reg     <= ch_reg[7:0];
                    prev_reg    <= code_reg;
                    prev_ok_reg <= 1'b1;
                    if (free_reg < CW'(TD) && prev_ok_reg) begin
                        free_reg <= free_reg + CW'(1);
                        if (free_reg + CW'(1) >= (CW'(1) << cwidth_reg)
                            && cwidth_reg < 4'(MAX_CODE_BITS))
                            cwidth_reg <= cwidth_reg + 4'd1;
                    end
                    state_reg <= S_EMIT;
                end
                S_POP: state_reg <= S_POP_WAIT;
                S_POP_WAIT: begin
                    sym_reg   <= stack_rd;
                    depth_reg <= depth_reg - (CW+1)'(1);
                    state_reg <= S_EMIT;
                end
                S_EMIT: begin
                    res_reg <= '{status: ST_PIXEL, cause: ERR_NONE, index: sym_reg,
                                 row: ras_row, column: ras_col,
                                 row_complete: ras_rc, in_frame: ras_inf};
                    if (ras_rc && ras_last) begin
                        fin_reg   <= FIN_DONE;
                        depth_reg <= '0;
                    end
                    state_reg <= S_RESP;
                end
                S_RESP: begin
                    m_valid_reg <= 1'b1;
                    state_reg   <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_status       = res_reg.status;
    assign m_error_cause  = res_reg.cause;
    assign m_pixel_index  = res_reg.index;
    assign m_pixel_row    = res_reg.row;
    assign m_pixel_column = res_reg.column;
    assign m_row_complete = res_reg.row_complete;
    assign m_in_frame     = res_reg.in_frame;

endmodule
